// File: src/accm_pkg.sv
`timescale 1ns / 1ps
package accm_pkg;

    localparam int MaxTagBytes = 4;
    localparam int QueueDepth  = 4;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_HEADER  = 2'd1,
        REQ_PAYLOAD = 2'd2,
        REQ_TAG     = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_TAG     = 2'd1,
        KIND_VERDICT = 2'd2
    } out_kind_t;

    typedef enum logic [2:0] {
        CFG_KEY_HIGH   = 3'd0,
        CFG_KEY_LOW    = 3'd1,
        CFG_NONCE_HIGH = 3'd2,
        CFG_NONCE_LOW  = 3'd3,
        CFG_MIC_LENGTH = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_TAG     = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_B0,
        ST_S0,
        ST_HDR_AES,
        ST_KS,
        ST_PAY,
        ST_MAC_AES,
        ST_TAGS,
        ST_VERDICT
    } back_state_t;

    typedef struct packed {
        req_kind_t   kind;
        logic        decrypt;
        logic [6:0]  hdr_len;
        logic [6:0]  pay_len;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } aes_stat_t;

    localparam logic [7:0] FLAG_ADATA = 8'h40;
    localparam logic [7:0] FLAG_BASE  = 8'h09;
    localparam logic [7:0] FLAG_CTR   = 8'h01;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte idx of a block, byte 0 being the most significant.
    function automatic logic [7:0] blk_byte(input logic [127:0] blk, input logic [3:0] idx);
        logic [127:0] t;
        t = blk << {idx, 3'b000};
        return t[127:120];
    endfunction

    function automatic logic [127:0] blk_xor_byte(input logic [127:0] blk,
                                                  input logic [3:0] idx,
                                                  input logic [7:0] b);
        return blk ^ ({b, 120'd0} >> {idx, 3'b000});
    endfunction

endpackage

// File: src/accm_front.sv
`timescale 1ns / 1ps
module accm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic              decrypt_mode,
    input  logic [6:0]        header_length,
    input  logic [6:0]        payload_length,
    input  logic [7:0]        data_byte,
    output accm_pkg::item_t   q_item,
    output logic              q_valid,
    input  logic              q_pop
);
    import accm_pkg::*;

    item_t      mem [QueueDepth];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       push;
    item_t      in_item;

    always_comb
    begin
        in_item.kind    = req_kind_t'(req_type);
        in_item.decrypt = decrypt_mode;
        in_item.hdr_len = header_length;
        in_item.pay_len = payload_length;
        in_item.data    = data_byte;
    end

    assign in_stall = (count_reg == 3'(QueueDepth));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 3'd0);
    assign q_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push) - 3'(q_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QueueDepth)) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !q_pop) |=> in_stall) else $error("full queue lost entries");

endmodule

// File: src/accm_aes.sv
`timescale 1ns / 1ps
module accm_aes (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [127:0]        blk_in,
    input  logic [127:0]        key,
    output logic [127:0]        result,
    output accm_pkg::aes_stat_t stat
);
    import accm_pkg::*;

    logic [127:0] st_reg, rk_reg;
    logic [3:0]   rnd_reg;
    logic [7:0]   rcon_reg;
    logic         busy_reg, done_reg;
    logic [127:0] rk_next, sub_shift, mixed, st_next;
    logic [31:0]  tmp;

    always_comb
    begin
        tmp = {SBOX[rk_reg[23:16]] ^ rcon_reg, SBOX[rk_reg[15:8]],
               SBOX[rk_reg[7:0]], SBOX[rk_reg[31:24]]};
        rk_next[127:96] = rk_reg[127:96] ^ tmp;
        rk_next[95:64]  = rk_reg[95:64] ^ rk_next[127:96];
        rk_next[63:32]  = rk_reg[63:32] ^ rk_next[95:64];
        rk_next[31:0]   = rk_reg[31:0] ^ rk_next[63:32];
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sub_shift[127 - 8 * (c * 4 + k) -: 8] =
                    SBOX[st_reg[127 - 8 * ((((c + k) % 4) * 4) + k) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, x;
            a0 = sub_shift[127 - 32 * c -: 8];
            a1 = sub_shift[119 - 32 * c -: 8];
            a2 = sub_shift[111 - 32 * c -: 8];
            a3 = sub_shift[103 - 32 * c -: 8];
            x  = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32 * c -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
            mixed[119 - 32 * c -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
            mixed[111 - 32 * c -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
            mixed[103 - 32 * c -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
        end
        st_next = ((rnd_reg == 4'd10) ? sub_shift : mixed) ^ rk_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            st_reg <= blk_in ^ key;
            rk_reg <= key;
        end
        else if (busy_reg)
        begin
            st_reg <= st_next;
            rk_reg <= rk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
            rcon_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
                rcon_reg <= 8'h01;
            end
            else if (busy_reg)
            begin
                rnd_reg  <= rnd_reg + 4'd1;
                rcon_reg <= xtime(rcon_reg);
                if (rnd_reg == 4'd10)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign result    = st_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("AES started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without work");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rnd_reg >= 4'd1 && rnd_reg <= 4'd10)) else $error("bad round");

endmodule

// File: src/accm_back.sv
`timescale 1ns / 1ps
module accm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  accm_pkg::item_t q_item,
    input  logic            q_valid,
    output logic            q_pop,
    input  logic [127:0]    key,
    input  logic [103:0]    nonce,
    input  logic [2:0]      mic_length,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic [1:0]      out_kind,
    output logic            auth_ok,
    output logic            last
);
    import accm_pkg::*;

    back_state_t  state_reg, state_next;
    phase_t       phase_reg, phase_next;
    logic [127:0] mac_reg, mac_next, ks_reg, ks_next;
    logic [31:0]  mask_reg, mask_next;
    logic [15:0]  ctr_reg, ctr_next;
    logic [4:0]   pos_reg, pos_next;
    logic [7:0]   left_reg, left_next;
    logic         dec_reg, dec_next;
    logic [6:0]   ptot_reg, ptot_next, hl_reg, hl_next;
    logic [2:0]   tlen_reg, tlen_next, j_reg, j_next;
    logic [7:0]   diff_reg, diff_next, dbyte_reg, dbyte_next;

    logic         ov_reg, ov_next, olast_reg, olast_next, ook_reg, ook_next;
    logic [7:0]   obyte_reg, obyte_next;
    out_kind_t    okind_reg, okind_next;

    logic         aes_start;
    logic [127:0] aes_blk, aes_res;
    aes_stat_t    aes_stat;
    logic         can_emit, go_bp, go_fin;
    logic [127:0] m_tmp;
    logic [7:0]   o_tmp;
    logic [3:0]   p4;

    accm_aes u_aes (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (aes_start),
        .blk_in (aes_blk),
        .key    (key),
        .result (aes_res),
        .stat   (aes_stat)
    );

    assign can_emit = !ov_reg || !out_stall;
    assign p4       = pos_reg[3:0];

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        mac_next   = mac_reg;
        ks_next    = ks_reg;
        mask_next  = mask_reg;
        ctr_next   = ctr_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        dec_next   = dec_reg;
        ptot_next  = ptot_reg;
        hl_next    = hl_reg;
        tlen_next  = tlen_reg;
        j_next     = j_reg;
        diff_next  = diff_reg;
        dbyte_next = dbyte_reg;
        ov_next    = ov_reg && out_stall;
        obyte_next = obyte_reg;
        okind_next = okind_reg;
        ook_next   = ook_reg;
        olast_next = olast_reg;
        q_pop      = 1'b0;
        aes_start  = 1'b0;
        aes_blk    = mac_reg;
        go_bp      = 1'b0;
        go_fin     = 1'b0;
        m_tmp      = '0;
        o_tmp      = '0;

        case (state_reg)
            ST_FETCH:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        REQ_START:
                        begin
                            dec_next  = q_item.decrypt;
                            ptot_next = q_item.pay_len;
                            hl_next   = q_item.hdr_len;
                            tlen_next = (mic_length > 3'(MaxTagBytes)) ?
                                        3'(MaxTagBytes) : mic_length;
                            aes_blk   = {((q_item.hdr_len != 7'd0) ? FLAG_ADATA : 8'h00)
                                         | FLAG_BASE, nonce, 9'd0, q_item.pay_len};
                            aes_start = 1'b1;
                            phase_next = PH_IDLE;
                            state_next = ST_B0;
                        end
                        REQ_HEADER:
                        begin
                            if (phase_reg == PH_HEADER)
                            begin
                                m_tmp     = blk_xor_byte(mac_reg, p4, q_item.data);
                                mac_next  = m_tmp;
                                pos_next  = pos_reg + 5'd1;
                                left_next = left_reg - 8'd1;
                                if (pos_reg == 5'd15 || left_reg == 8'd1)
                                begin
                                    aes_blk    = m_tmp;
                                    aes_start  = 1'b1;
                                    state_next = ST_HDR_AES;
                                end
                            end
                        end
                        REQ_PAYLOAD:
                        begin
                            if (phase_reg == PH_PAYLOAD)
                            begin
                                dbyte_next = q_item.data;
                                if (pos_reg == 5'd0)
                                begin
                                    aes_blk    = {FLAG_CTR, nonce, ctr_reg};
                                    aes_start  = 1'b1;
                                    state_next = ST_KS;
                                end
                                else
                                begin
                                    state_next = ST_PAY;
                                end
                            end
                        end
                        REQ_TAG:
                        begin
                            if (phase_reg == PH_TAG)
                            begin
                                if (pos_reg < 5'(MaxTagBytes))
                                begin
                                    diff_next = diff_reg | (q_item.data
                                        ^ blk_byte({mask_reg, 96'd0}, p4)
                                        ^ blk_byte(mac_reg, p4));
                                end
                                pos_next  = pos_reg + 5'd1;
                                left_next = left_reg - 8'd1;
                                if (left_reg == 8'd1)
                                begin
                                    phase_next = PH_IDLE;
                                    state_next = ST_VERDICT;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_B0:
            begin
                if (aes_stat.done)
                begin
                    mac_next   = aes_res;
                    aes_blk    = {FLAG_CTR, nonce, 16'd0};
                    aes_start  = 1'b1;
                    state_next = ST_S0;
                end
            end
            ST_S0:
            begin
                if (aes_stat.done)
                begin
                    mask_next = aes_res[127:96];
                    ctr_next  = 16'd1;
                    state_next = ST_FETCH;
                    if (hl_reg != 7'd0)
                    begin
                        mac_next   = blk_xor_byte(mac_reg, 4'd1, {1'b0, hl_reg});
                        pos_next   = 5'd2;
                        left_next  = {1'b0, hl_reg};
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        go_bp = 1'b1;
                    end
                end
            end
            ST_HDR_AES:
            begin
                if (aes_stat.done)
                begin
                    mac_next   = aes_res;
                    pos_next   = 5'd0;
                    state_next = ST_FETCH;
                    if (left_reg == 8'd0)
                    begin
                        go_bp = 1'b1;
                    end
                end
            end
            ST_KS:
            begin
                if (aes_stat.done)
                begin
                    ks_next    = aes_res;
                    ctr_next   = ctr_reg + 16'd1;
                    state_next = ST_PAY;
                end
            end
            ST_PAY:
            begin
                if (can_emit)
                begin
                    o_tmp      = blk_byte(ks_reg, p4) ^ dbyte_reg;
                    m_tmp      = blk_xor_byte(mac_reg, p4, dec_reg ? o_tmp : dbyte_reg);
                    mac_next   = m_tmp;
                    pos_next   = pos_reg + 5'd1;
                    left_next  = left_reg - 8'd1;
                    ov_next    = 1'b1;
                    obyte_next = o_tmp;
                    okind_next = KIND_PAYLOAD;
                    ook_next   = 1'b0;
                    olast_next = !dec_reg && (tlen_reg == 3'd0) && (left_reg == 8'd1);
                    state_next = ST_FETCH;
                    if (pos_reg == 5'd15 || left_reg == 8'd1)
                    begin
                        aes_blk    = m_tmp;
                        aes_start  = 1'b1;
                        state_next = ST_MAC_AES;
                    end
                end
            end
            ST_MAC_AES:
            begin
                if (aes_stat.done)
                begin
                    mac_next   = aes_res;
                    pos_next   = 5'd0;
                    state_next = ST_FETCH;
                    if (left_reg == 8'd0)
                    begin
                        go_fin = 1'b1;
                    end
                end
            end
            ST_TAGS:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    obyte_next = blk_byte(mac_reg, {1'b0, j_reg})
                               ^ blk_byte({mask_reg, 96'd0}, {1'b0, j_reg});
                    okind_next = KIND_TAG;
                    ook_next   = 1'b0;
                    olast_next = (j_reg + 3'd1 == tlen_reg);
                    j_next     = j_reg + 3'd1;
                    if (j_reg + 3'd1 == tlen_reg)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_VERDICT:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    obyte_next = 8'd0;
                    okind_next = KIND_VERDICT;
                    ook_next   = (diff_reg == 8'd0);
                    olast_next = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase

        // Entering the payload phase, and closing the frame when it is empty.
        if (go_bp)
        begin
            pos_next   = 5'd0;
            left_next  = {1'b0, ptot_reg};
            phase_next = PH_PAYLOAD;
            if (ptot_reg == 7'd0)
            begin
                go_fin = 1'b1;
            end
        end
        if (go_fin)
        begin
            phase_next = PH_IDLE;
            state_next = ST_FETCH;
            if (!dec_reg)
            begin
                if (tlen_reg != 3'd0)
                begin
                    j_next     = 3'd0;
                    state_next = ST_TAGS;
                end
            end
            else if (tlen_reg == 3'd0)
            begin
                diff_next  = 8'd0;
                state_next = ST_VERDICT;
            end
            else
            begin
                phase_next = PH_TAG;
                left_next  = {5'd0, tlen_reg};
                pos_next   = 5'd0;
                diff_next  = 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg   <= mac_next;
        ks_reg    <= ks_next;
        mask_reg  <= mask_next;
        ctr_reg   <= ctr_next;
        ptot_reg  <= ptot_next;
        hl_reg    <= hl_next;
        j_reg     <= j_next;
        dbyte_reg <= dbyte_next;
        obyte_reg <= obyte_next;
        okind_reg <= okind_next;
        ook_reg   <= ook_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FETCH;
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            left_reg  <= '0;
            dec_reg   <= 1'b0;
            tlen_reg  <= '0;
            diff_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            dec_reg   <= dec_next;
            tlen_reg  <= tlen_next;
            diff_reg  <= diff_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = obyte_reg;
    assign out_kind  = okind_reg;
    assign auth_ok   = ook_reg;
    assign last      = olast_reg;

    a_aes_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        aes_start |-> !aes_stat.busy) else $error("AES request while busy");
    a_tags_encrypt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAGS) |-> (!dec_reg && tlen_reg != 3'd0))
        else $error("tag emission outside encrypt");
    a_header_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER && state_reg == ST_FETCH) |-> left_reg != 8'd0)
        else $error("header phase with no bytes left");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_FETCH) else $error("item taken mid-operation");

endmodule

// File: src/aes_ccm_star_frame_crypt.sv
`timescale 1ns / 1ps
// A header byte that closes a CBC-MAC block waits for an AES run of that block. A payload
// byte that opens a keystream block waits for an AES run of the counter block before its result
// is registered in the output register. A start runs two encryptions, B0 and then S0.
// The iterative AES core (one round per cycle) runs two encryptions per 16-byte payload
// block, one for the keystream and one for the CBC-MAC.
// Reset (rst_n, asynchronous, active low) empties the input queue, idles the frame sequencer
// and the AES core, and loads mic_length with 4 and the key and nonce with zero.
module aes_ccm_star_frame_crypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        decrypt_mode,
    input  logic [6:0]  header_length,
    input  logic [6:0]  payload_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  out_kind,
    output logic        auth_ok,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import accm_pkg::*;

    // Configuration registers. Writes are always taken; an index beyond the list is dropped.
    logic [63:0] key_high_reg, key_low_reg, nonce_low_reg;
    logic [39:0] nonce_high_reg;
    logic [2:0]  mic_length_reg;

    item_t q_item;
    logic  q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            nonce_high_reg <= '0;
            nonce_low_reg  <= '0;
            mic_length_reg <= 3'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_NONCE_HIGH: nonce_high_reg <= cfg_data[39:0];
                CFG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                CFG_MIC_LENGTH: mic_length_reg <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    // The front end queues each input transaction so the sequencer can stall on AES work
    // while the upstream side keeps sending.
    accm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .decrypt_mode   (decrypt_mode),
        .header_length  (header_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .q_item         (q_item),
        .q_valid        (q_valid),
        .q_pop          (q_pop)
    );

    // The back end runs the CCM* frame: CBC-MAC chaining, counter keystream and tag handling.
    // Its output register holds a result while the next queued transaction is worked on.
    accm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .key        ({key_high_reg, key_low_reg}),
        .nonce      ({nonce_high_reg, nonce_low_reg}),
        .mic_length (mic_length_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .auth_ok    (auth_ok),
        .last       (last)
    );

endmodule

// File: tb/sv/aes_ccm_star_frame_crypt_checker.sv
`timescale 1ns / 1ps
module aes_ccm_star_frame_crypt_checker
    import accm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        decrypt_mode,
    input  logic [6:0]  header_length,
    input  logic [6:0]  payload_length,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic [1:0]  out_kind,
    input  logic        auth_ok,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          error_count,
    output int          pending,
    output logic [31:0] tag_expected
);

    typedef struct {
        logic [7:0] value;
        out_kind_t  kind;
        logic       ok;
        logic       fin;
    } crypt_result_t;

    crypt_result_t result_q[$];

    logic [7:0]   sub_bytes [256];
    logic [63:0]  key_hi, key_lo, nonce_lo;
    logic [39:0]  nonce_hi;
    logic [2:0]   mic_reg;
    logic [127:0] mac_state, key_stream;
    logic [31:0]  mask_bytes;
    logic [15:0]  ctr_value;
    logic [4:0]   byte_pos;
    logic [7:0]   remaining;
    phase_t       phase;
    logic         decrypting;
    logic [6:0]   payload_total;
    logic [2:0]   tag_count;
    logic [7:0]   tag_miss;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // The S-box is derived from the field inverse plus the affine map.
    initial
    begin
        logic [7:0] inv;
        for (int v = 0; v < 256; v++)
        begin
            inv = 8'h00;
            for (int w = 1; w < 256; w++)
                if (gf_mul(v[7:0], w[7:0]) == 8'h01)
                    inv = w[7:0];
            sub_bytes[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                           ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    end

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
        logic [7:0]   rk [176];
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   tmp [4];
        logic [7:0]   f, rcon, a0, a1, a2, a3, x;
        logic [127:0] key;
        logic [127:0] res;
        key = {key_hi, key_lo};
        rcon = 8'h01;
        for (int i = 0; i < 16; i++)
            rk[i] = key[127 - 8 * i -: 8];
        for (int i = 16; i < 176; i += 4)
        begin
            for (int k = 0; k < 4; k++)
                tmp[k] = rk[i - 4 + k];
            if (i % 16 == 0)
            begin
                f = tmp[0];
                tmp[0] = sub_bytes[tmp[1]] ^ rcon;
                tmp[1] = sub_bytes[tmp[2]];
                tmp[2] = sub_bytes[tmp[3]];
                tmp[3] = sub_bytes[f];
                rcon = dbl(rcon);
            end
            for (int k = 0; k < 4; k++)
                rk[i + k] = rk[i - 16 + k] ^ tmp[k];
        end
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    t[c * 4 + k] = sub_bytes[s[((c + k) % 4) * 4 + k]];
            if (r < 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[c * 4];
                    a1 = t[c * 4 + 1];
                    a2 = t[c * 4 + 2];
                    a3 = t[c * 4 + 3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    t[c * 4]     = a0 ^ x ^ dbl(a0 ^ a1);
                    t[c * 4 + 1] = a1 ^ x ^ dbl(a1 ^ a2);
                    t[c * 4 + 2] = a2 ^ x ^ dbl(a2 ^ a3);
                    t[c * 4 + 3] = a3 ^ x ^ dbl(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[r * 16 + i];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    function automatic logic [127:0] ccm_block(input logic [7:0] flags, input logic [15:0] tail);
        return {flags, nonce_hi, nonce_lo, tail};
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] blk, input int idx);
        return blk[127 - 8 * idx -: 8];
    endfunction

    task automatic add_result(input logic [7:0] v, input out_kind_t k, input logic ok,
                              input logic fin);
        crypt_result_t r;
        r.value = v;
        r.kind = k;
        r.ok = ok;
        r.fin = fin;
        result_q.push_back(r);
    endtask

    task automatic close_mac_block();
        if (byte_pos != 0)
        begin
            mac_state = aes_encrypt(mac_state);
            byte_pos = 0;
        end
    endtask

    task automatic finish_frame(input int produced);
        phase = PH_IDLE;
        if (!decrypting)
        begin
            for (int j = 0; j < tag_count; j++)
                add_result(byte_at(mac_state, j) ^ mask_bytes[31 - 8 * j -: 8], KIND_TAG, 1'b0,
                           j + 1 == tag_count);
            if (tag_count == 0 && produced > 0)
                result_q[$].fin = 1'b1;
        end
        else if (tag_count == 0)
            add_result(8'h00, KIND_VERDICT, 1'b1, 1'b1);
        else
        begin
            phase = PH_TAG;
            remaining = tag_count;
            byte_pos = 0;
            tag_miss = 0;
        end
    endtask

    task automatic start_payload(input int produced);
        byte_pos = 0;
        remaining = payload_total;
        phase = PH_PAYLOAD;
        if (payload_total == 0)
            finish_frame(produced);
    endtask

    task automatic predict_transaction();
        logic [127:0] s0;
        logic [7:0]   o;
        int           p;
        case (req_kind_t'(req_type))
            REQ_START:
            begin
                tag_count = (mic_reg > MaxTagBytes) ? 3'(MaxTagBytes) : mic_reg;
                decrypting = decrypt_mode;
                payload_total = payload_length;
                mac_state = aes_encrypt(ccm_block((header_length != 0 ? 8'h40 : 8'h00) | 8'h09,
                                                  {9'd0, payload_length}));
                s0 = aes_encrypt(ccm_block(8'h01, 16'd0));
                mask_bytes = s0[127:96];
                ctr_value = 1;
                if (header_length != 0)
                begin
                    mac_state[119:112] ^= {1'b0, header_length};
                    byte_pos = 2;
                    remaining = {1'b0, header_length};
                    phase = PH_HEADER;
                end
                else
                    start_payload(0);
            end
            REQ_HEADER:
                if (phase == PH_HEADER)
                begin
                    p = byte_pos & 15;
                    mac_state[127 - 8 * p -: 8] ^= data_byte;
                    byte_pos = byte_pos + 1;
                    if (byte_pos >= 16)
                        close_mac_block();
                    remaining--;
                    if (remaining == 0)
                    begin
                        close_mac_block();
                        start_payload(0);
                    end
                end
            REQ_PAYLOAD:
                if (phase == PH_PAYLOAD)
                begin
                    p = byte_pos & 15;
                    if (p == 0)
                    begin
                        key_stream = aes_encrypt(ccm_block(8'h01, ctr_value));
                        ctr_value++;
                    end
                    o = byte_at(key_stream, p) ^ data_byte;
                    mac_state[127 - 8 * p -: 8] ^= decrypting ? o : data_byte;
                    byte_pos = 5'(p + 1);
                    if (byte_pos >= 16)
                        close_mac_block();
                    add_result(o, KIND_PAYLOAD, 1'b0, 1'b0);
                    remaining--;
                    if (remaining == 0)
                    begin
                        close_mac_block();
                        finish_frame(1);
                    end
                end
            REQ_TAG:
                if (phase == PH_TAG)
                begin
                    p = byte_pos;
                    if (p < MaxTagBytes)
                        tag_miss |= data_byte ^ mask_bytes[31 - 8 * p -: 8]
                                    ^ byte_at(mac_state, p);
                    byte_pos = byte_pos + 1;
                    remaining--;
                    if (remaining == 0)
                    begin
                        phase = PH_IDLE;
                        add_result(8'h00, KIND_VERDICT, tag_miss == 0, 1'b1);
                    end
                end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        crypt_result_t want;
        if (!rst_n)
        begin
            key_hi <= '0;
            key_lo <= '0;
            nonce_hi <= '0;
            nonce_lo <= '0;
            mic_reg <= 3'd4;
            mac_state <= '0;
            key_stream <= '0;
            mask_bytes <= '0;
            ctr_value <= '0;
            byte_pos <= '0;
            remaining <= '0;
            phase <= PH_IDLE;
            decrypting <= 1'b0;
            payload_total <= '0;
            tag_count <= '0;
            tag_miss <= '0;
            error_count <= 0;
            pending <= 0;
            tag_expected <= '0;
            result_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index_t'(cfg_index))
                    CFG_KEY_HIGH:   key_hi = cfg_data;
                    CFG_KEY_LOW:    key_lo = cfg_data;
                    CFG_NONCE_HIGH: nonce_hi = cfg_data[39:0];
                    CFG_NONCE_LOW:  nonce_lo = cfg_data;
                    CFG_MIC_LENGTH: mic_reg = cfg_data[2:0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
                predict_transaction();
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result: byte %h kind %0d ok %0d last %0d",
                           out_byte, out_kind, auth_ok, last);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (out_byte !== want.value || out_kind !== want.kind
                        || auth_ok !== want.ok || last !== want.fin)
                        error_count <= error_count + 1;
                    if (out_byte !== want.value)
                        $error("out_byte: expected %h, actual %h", want.value, out_byte);
                    if (out_kind !== want.kind)
                        $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
                    if (auth_ok !== want.ok)
                        $error("auth_ok: expected %0d, actual %0d", want.ok, auth_ok);
                    if (last !== want.fin)
                        $error("last: expected %0d, actual %0d", want.fin, last);
                end
            end
            pending <= result_q.size();
            tag_expected <= mac_state[127:96] ^ mask_bytes;
        end
    end

endmodule

// File: tb/sv/aes_ccm_star_frame_crypt_tb.sv
`timescale 1ns / 1ps
module aes_ccm_star_frame_crypt_tb;
    import accm_pkg::*;

    // A run is abandoned once this many cycles pass with no transaction on any channel.
    localparam int StallLimit = 4000;
    // The slowest silent stretch is a full input queue of starts plus the one in work,
    // five starts in all.
    localparam int SettleCycles = 150;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic        decrypt_mode;
    logic [6:0]  header_length;
    logic [6:0]  payload_length;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic        auth_ok;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int          error_count;
    int          pending;
    logic [31:0] tag_expected;

    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          items_sent;
    int          quiet_cycles;
    logic [2:0]  mic_now;

    aes_ccm_star_frame_crypt DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .decrypt_mode   (decrypt_mode),
        .header_length  (header_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_kind       (out_kind),
        .auth_ok        (auth_ok),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    aes_ccm_star_frame_crypt_checker frame_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .decrypt_mode   (decrypt_mode),
        .header_length  (header_length),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_kind       (out_kind),
        .auth_ok        (auth_ok),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .error_count    (error_count),
        .pending        (pending),
        .tag_expected   (tag_expected)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The result side stalls at random with the rate of the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Watchdog: counts cycles in which no channel completes a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drives one input transaction and holds it until the block takes it. Valid is left
    // high afterwards so that back-to-back transactions need only one assignment per edge.
    task automatic send_item(input req_kind_t kind, input logic dec, input logic [6:0] hl,
                             input logic [6:0] pl, input logic [7:0] d);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        decrypt_mode <= dec;
        header_length <= hl;
        payload_length <= pl;
        data_byte <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Register writes keep valid high between writes; the caller lowers it afterwards.
    task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MIC_LENGTH)
            mic_now = value[2:0];
    endtask

    // The block is idle once every predicted result has arrived and the longest silent
    // operation has had time to complete.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic load_settings(input logic [63:0] k_hi, input logic [63:0] k_lo,
                                 input logic [63:0] n_hi, input logic [63:0] n_lo,
                                 input logic [2:0] mic);
        wait_idle();
        write_reg(CFG_KEY_HIGH, k_hi);
        write_reg(CFG_KEY_LOW, k_lo);
        write_reg(CFG_NONCE_HIGH, n_hi);
        write_reg(CFG_NONCE_LOW, n_lo);
        write_reg(CFG_MIC_LENGTH, {61'd0, mic});
        cfg_valid <= 1'b0;
    endtask

    // One frame: start, header bytes, payload bytes and, when decrypting, the received tag.
    // A cut frame stops after cut_at transactions, so the next start abandons it.
    // A bad tag flips one random bit of the correct tag.
    task automatic run_frame(input logic dec, input logic [6:0] hl, input logic [6:0] pl,
                             input int cut_at, input logic bad_tag);
        int          sent;
        int          tlen;
        logic [31:0] tag;
        sent = 0;
        tlen = (mic_now > MaxTagBytes) ? MaxTagBytes : mic_now;
        send_item(REQ_START, dec, hl, pl, 8'($urandom));
        sent++;
        for (int i = 0; i < hl && sent != cut_at; i++)
        begin
            send_item(REQ_HEADER, 1'($urandom), 7'($urandom), 7'($urandom), 8'($urandom));
            sent++;
        end
        for (int i = 0; i < pl && sent != cut_at; i++)
        begin
            send_item(REQ_PAYLOAD, 1'($urandom), 7'($urandom), 7'($urandom), 8'($urandom));
            sent++;
        end
        if (dec && tlen > 0 && sent != cut_at)
        begin
            // Pausing the input lets the checker publish the tag of this frame.
            in_valid <= 1'b0;
            @(posedge clk);
            tag = tag_expected;
            if (bad_tag)
                tag[$urandom_range(8 * tlen - 1, 0) + 8 * (4 - tlen)] ^= 1'b1;
            for (int i = 0; i < tlen && sent != cut_at; i++)
            begin
                send_item(REQ_TAG, 1'($urandom), 7'($urandom), 7'($urandom),
                          tag[31 - 8 * i -: 8]);
                sent++;
            end
        end
    endtask

    task automatic random_frame();
        int         pick;
        logic [6:0] hl;
        logic [6:0] pl;
        pick = $urandom_range(99);
        hl = ($urandom_range(99) < 3) ? 7'($urandom_range(127, 64)) : 7'($urandom_range(20));
        pl = ($urandom_range(99) < 3) ? 7'($urandom_range(127, 64)) : 7'($urandom_range(20));
        if (pick < 10)
            // Noise: a header, payload or tag item, most often ignored by the block.
            send_item(req_kind_t'($urandom_range(3, 1)), 1'($urandom), 7'($urandom),
                      7'($urandom), 8'($urandom));
        else if (pick < 20)
            run_frame(1'($urandom), hl, pl, $urandom_range(hl + pl + 4, 1), 1'b0);
        else
            run_frame(1'($urandom), hl, pl, -1, $urandom_range(99) < 30);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_START;
        decrypt_mode = 1'b0;
        header_length = '0;
        payload_length = '0;
        data_byte = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEY_HIGH;
        cfg_data = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        items_sent = 0;
        quiet_cycles = 0;
        mic_now = 3'd4;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: first with the reset settings, then with a known key.
        run_frame(1'b0, 7'd0, 7'd0, -1, 1'b0);
        load_settings(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314,
                      64'h15161718191a1b1c, 3'd4);
        run_frame(1'b0, 7'd3, 7'd5, -1, 1'b0);
        run_frame(1'b1, 7'd0, 7'd2, -1, 1'b0);
        run_frame(1'b1, 7'd1, 7'd1, -1, 1'b1);
        // Items that do not fit the current phase are dropped without a result.
        send_item(REQ_HEADER, 1'b0, 7'd0, 7'd0, 8'hff);
        send_item(REQ_TAG, 1'b1, 7'd127, 7'd127, 8'h00);
        // A start in the middle of a frame abandons it.
        run_frame(1'b0, 7'd2, 7'd4, 3, 1'b0);
        // Zero tag length: the last payload byte ends an encrypted frame, and a
        // decrypted one passes at once.
        load_settings(64'h0, 64'h0, 64'h0, 64'h0, 3'd0);
        run_frame(1'b0, 7'd0, 7'd2, -1, 1'b0);
        run_frame(1'b1, 7'd0, 7'd1, -1, 1'b0);
        run_frame(1'b0, 7'd0, 7'd0, -1, 1'b0);

        // Random part, one block of frames for each idling pattern and key setting.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    load_settings('1, '1, '1, '1, 3'd7);
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    load_settings({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, 3'd2);
                    sender_idle_pct = 68;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    load_settings({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, 3'd1);
                    sender_idle_pct = 0;
                    receiver_stall_pct = 68;
                end
                default:
                begin
                    load_settings({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, 3'd4);
                    sender_idle_pct = 11;
                    receiver_stall_pct = 11;
                end
            endcase
            // One frame of maximum header in the first setting and one of maximum payload in the second.
            if (ph == 0)
                run_frame(1'b0, 7'd127, 7'd1, -1, 1'b0);
            if (ph == 1)
                run_frame(1'b1, 7'd0, 7'd127, -1, 1'b0);
            while (items_sent < 25 + 115 * (ph + 1))
                random_frame();
        end

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
src/accm_pkg.sv
src/accm_front.sv
src/accm_aes.sv
src/accm_back.sv
src/aes_ccm_star_frame_crypt.sv
tb/sv/aes_ccm_star_frame_crypt_checker.sv
tb/sv/aes_ccm_star_frame_crypt_tb.sv
